// File: src/tss_pkg.sv
// shared types and constants for the tlv type search unit
package tss_pkg;

	localparam int unsigned OFFSET_BITS_DEF = 16;
	localparam int unsigned BYTE_BITS       = 8;
	localparam int unsigned LEN_BITS        = 16;

	// length byte value that announces a 16-bit extended length
	localparam logic [BYTE_BITS-1:0] EXT_MARK = 8'hFF;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LEN,
		PH_EXT_HI,
		PH_EXT_LO,
		PH_SKIP,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic first;
		logic last;
	} item_ctl_t;

endpackage

// File: src/tss_in_if.sv
// request channel carrying one message byte with its region markers
interface tss_in_if #(
	parameter int unsigned OFFSET_BITS = tss_pkg::OFFSET_BITS_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic [tss_pkg::BYTE_BITS-1:0]  data_byte;
	logic                           first;
	logic                           last;
	logic [tss_pkg::BYTE_BITS-1:0]  target_type;
	logic [OFFSET_BITS-1:0]         start_offset;
	logic [OFFSET_BITS-1:0]         end_offset;

	modport source (
		output valid, data_byte, first, last, target_type, start_offset, end_offset,
		input  ready
	);
	modport sink (
		input  valid, data_byte, first, last, target_type, start_offset, end_offset,
		output ready
	);
endinterface

// File: src/tss_out_if.sv
// result channel carrying the search outcome of one region
interface tss_out_if #(
	parameter int unsigned OFFSET_BITS = tss_pkg::OFFSET_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [OFFSET_BITS-1:0]        tlv_offset;
	logic [OFFSET_BITS-1:0]        value_offset;
	logic [tss_pkg::LEN_BITS-1:0]  value_length;

	modport source (
		output valid, found, tlv_offset, value_offset, value_length,
		input  ready
	);
	modport sink (
		input  valid, found, tlv_offset, value_offset, value_length,
		output ready
	);
endinterface

// File: src/tss_in_reg.sv
// input register stage holding one accepted byte request
module tss_in_reg #(
	parameter int unsigned OFFSET_BITS = tss_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tss_in_if.sink                        req,
	input  logic                          consume,
	output logic                          valid_s1,
	output tss_pkg::item_ctl_t            ctl_s1,
	output logic [tss_pkg::BYTE_BITS-1:0] byte_s1,
	output logic [tss_pkg::BYTE_BITS-1:0] target_s1,
	output logic [OFFSET_BITS-1:0]        start_s1,
	output logic [OFFSET_BITS-1:0]        end_s1
);
	logic take_in;

	assign req.ready = !valid_s1 || consume;
	assign take_in   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ctl_s1.first <= req.first;
			ctl_s1.last  <= req.last;
			byte_s1      <= req.data_byte;
			target_s1    <= req.target_type;
			start_s1     <= req.start_offset;
			end_s1       <= req.end_offset;
		end
	end
endmodule

// File: src/tss_walker.sv
// tlv walker state and one-byte parse step
module tss_walker #(
	parameter int unsigned OFFSET_BITS = tss_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  tss_pkg::item_ctl_t            ctl,
	input  logic [tss_pkg::BYTE_BITS-1:0] data_byte,
	input  logic [tss_pkg::BYTE_BITS-1:0] target_type,
	input  logic [OFFSET_BITS-1:0]        start_offset,
	input  logic [OFFSET_BITS-1:0]        end_offset,
	output logic                          res_valid,
	output logic                          found,
	output logic [OFFSET_BITS-1:0]        tlv_offset,
	output logic [OFFSET_BITS-1:0]        value_offset,
	output logic [tss_pkg::LEN_BITS-1:0]  value_length
);
	localparam int unsigned LB    = tss_pkg::LEN_BITS;
	localparam int unsigned BB    = tss_pkg::BYTE_BITS;
	localparam int unsigned CMP_W = (OFFSET_BITS > LB) ? OFFSET_BITS : LB;

	tss_pkg::phase_t         phase_q, ph, ph_n;
	logic [OFFSET_BITS-1:0]  pos_q, pos, pos_n;
	logic [OFFSET_BITS-1:0]  rend_q, rend;
	logic [BB-1:0]           want_q, want;
	logic [LB-1:0]           skip_q, skip, skip_n;
	logic [BB-1:0]           exth_q, exth, exth_n;
	logic                    tm_q, tm, tm_n;
	logic [OFFSET_BITS-1:0]  hs_q, hs, hs_n;
	logic                    hit_q, hit, hit_n;
	logic [OFFSET_BITS-1:0]  htlv_q, htlv, htlv_n;
	logic [OFFSET_BITS-1:0]  hvoff_q, hvoff, hvoff_n;
	logic [LB-1:0]           hlen_q, hlen, hlen_n;

	logic                    in_range;
	logic [OFFSET_BITS-1:0]  voff;
	logic [OFFSET_BITS-1:0]  room;
	logic [LB-1:0]           hdr_len;
	logic                    fits;
	logic                    hdr_done;

	always_comb begin
		// a first request restarts the search before its byte is taken
		ph    = phase_q;
		pos   = pos_q;
		rend  = rend_q;
		want  = want_q;
		skip  = skip_q;
		exth  = exth_q;
		tm    = tm_q;
		hs    = hs_q;
		hit   = hit_q;
		htlv  = htlv_q;
		hvoff = hvoff_q;
		hlen  = hlen_q;
		if (ctl.first) begin
			ph    = tss_pkg::PH_TYPE;
			pos   = start_offset;
			rend  = end_offset;
			want  = target_type;
			skip  = '0;
			exth  = '0;
			tm    = 1'b0;
			hs    = '0;
			hit   = 1'b0;
			htlv  = '0;
			hvoff = '0;
			hlen  = '0;
		end

		in_range = pos < rend;
		voff     = pos + OFFSET_BITS'(1);
		room     = rend - voff;
		hdr_len  = (ph == tss_pkg::PH_LEN) ? LB'(data_byte) : {exth, data_byte};
		fits     = CMP_W'(hdr_len) <= CMP_W'(room);

		ph_n     = ph;
		pos_n    = pos;
		skip_n   = skip;
		exth_n   = exth;
		tm_n     = tm;
		hs_n     = hs;
		hit_n    = hit;
		htlv_n   = htlv;
		hvoff_n  = hvoff;
		hlen_n   = hlen;
		hdr_done = 1'b0;

		if (in_range) begin
			pos_n = voff;
			unique case (ph)
				tss_pkg::PH_TYPE: begin
					hs_n = pos;
					tm_n = (data_byte == want);
					ph_n = tss_pkg::PH_LEN;
				end
				tss_pkg::PH_LEN: begin
					if (data_byte == tss_pkg::EXT_MARK) begin
						ph_n = tss_pkg::PH_EXT_HI;
					end else begin
						hdr_done = 1'b1;
					end
				end
				tss_pkg::PH_EXT_HI: begin
					exth_n = data_byte;
					ph_n   = tss_pkg::PH_EXT_LO;
				end
				tss_pkg::PH_EXT_LO: begin
					hdr_done = 1'b1;
				end
				tss_pkg::PH_SKIP: begin
					skip_n = skip - LB'(1);
					if (skip_n == '0) begin
						ph_n = tss_pkg::PH_TYPE;
					end
				end
				default: begin
				end
			endcase

			if (hdr_done) begin
				if (fits) begin
					if (tm) begin
						hit_n   = 1'b1;
						htlv_n  = hs;
						hvoff_n = voff;
						hlen_n  = hdr_len;
						ph_n    = tss_pkg::PH_DONE;
					end else if (hdr_len == '0) begin
						ph_n = tss_pkg::PH_TYPE;
					end else begin
						skip_n = hdr_len;
						ph_n   = tss_pkg::PH_SKIP;
					end
				end else begin
					ph_n = tss_pkg::PH_DONE;
				end
			end
		end

		if (ctl.last) begin
			ph_n = tss_pkg::PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tss_pkg::PH_TYPE;
			pos_q   <= '0;
			rend_q  <= '0;
			want_q  <= '0;
			skip_q  <= '0;
			exth_q  <= '0;
			tm_q    <= 1'b0;
			hs_q    <= '0;
			hit_q   <= 1'b0;
			htlv_q  <= '0;
			hvoff_q <= '0;
			hlen_q  <= '0;
		end else if (take) begin
			phase_q <= ph_n;
			pos_q   <= pos_n;
			rend_q  <= rend;
			want_q  <= want;
			skip_q  <= skip_n;
			exth_q  <= exth_n;
			tm_q    <= tm_n;
			hs_q    <= hs_n;
			hit_q   <= hit_n;
			htlv_q  <= htlv_n;
			hvoff_q <= hvoff_n;
			hlen_q  <= hlen_n;
		end
	end

	// hit fields stay zero until a match, so they go out unmasked
	assign res_valid    = take && ctl.last;
	assign found        = hit_n;
	assign tlv_offset   = htlv_n;
	assign value_offset = hvoff_n;
	assign value_length = hlen_n;

	a_hit_settles: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> phase_q == tss_pkg::PH_DONE)
		else $error("hit recorded while walk still running");

	a_hit_geometry: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (hvoff_q == htlv_q + OFFSET_BITS'(2)) ||
			(hvoff_q == htlv_q + OFFSET_BITS'(4)))
		else $error("value offset not two or four past the type byte");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		take && ctl.last |=> phase_q == tss_pkg::PH_DONE)
		else $error("walk not closed after last byte");
endmodule

// File: src/tss_out_reg.sv
// result register facing the result channel
module tss_out_reg #(
	parameter int unsigned OFFSET_BITS = tss_pkg::OFFSET_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         res_valid,
	input  logic                         found,
	input  logic [OFFSET_BITS-1:0]       tlv_offset,
	input  logic [OFFSET_BITS-1:0]       value_offset,
	input  logic [tss_pkg::LEN_BITS-1:0] value_length,
	output logic                         free,
	tss_out_if.source                    res
);
	logic valid_q;

	assign free      = !valid_q || res.ready;
	assign res.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && free) begin
			res.found        <= found;
			res.tlv_offset   <= tlv_offset;
			res.value_offset <= value_offset;
			res.value_length <= value_length;
		end
	end
endmodule

// File: src/tlv_type_search_unit.sv
// top level of the streaming tlv type search unit
//
// usage:
//  byte_ch carries one message byte per request together with first/last
//  markers; the request marked first also supplies the wanted type, the
//  absolute offset of its byte and the exclusive end offset of the message
//  result_ch returns one result per request marked last: found, the offset
//  of the matching type byte, the value offset and the value length (all
//  zero when nothing matched)
//  bytes at or beyond the end offset are ignored, and once a match is made
//  or the walk fails the rest of the region changes nothing
// result path: an accepted request waits in the input register; the parse step
//  reads it there and loads a last request's result into the result register
// throughput: one request per cycle unless a last request waits on the result
//  register; parse step: byte compares, offset add and subtract, length-fits compare
// reset: arst_n clears the walker to "expect type byte" with an empty region,
//  so a last before any first reports not found; both channels go empty
// stall: while the result register holds an untaken result, a held last
//  request waits in the input register; other requests keep flowing, and
//  byte_ch ready drops only when a last request is blocked behind the result
module tlv_type_search_unit #(
	parameter int unsigned OFFSET_BITS = tss_pkg::OFFSET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tss_in_if.sink    byte_ch,
	tss_out_if.source result_ch
);
	logic                          valid_s1;
	tss_pkg::item_ctl_t            ctl_s1;
	logic [tss_pkg::BYTE_BITS-1:0] byte_s1;
	logic [tss_pkg::BYTE_BITS-1:0] target_s1;
	logic [OFFSET_BITS-1:0]        start_s1;
	logic [OFFSET_BITS-1:0]        end_s1;

	logic                          out_free;
	logic                          consume;
	logic                          take;

	logic                          res_valid;
	logic                          found;
	logic [OFFSET_BITS-1:0]        tlv_offset;
	logic [OFFSET_BITS-1:0]        value_offset;
	logic [tss_pkg::LEN_BITS-1:0]  value_length;

	// a non-last byte never needs the result register
	assign consume = !ctl_s1.last || out_free;
	assign take    = valid_s1 && consume;

	tss_in_reg #(.OFFSET_BITS(OFFSET_BITS)) u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (byte_ch),
		.consume   (consume),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.byte_s1   (byte_s1),
		.target_s1 (target_s1),
		.start_s1  (start_s1),
		.end_s1    (end_s1)
	);

	tss_walker #(.OFFSET_BITS(OFFSET_BITS)) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.ctl          (ctl_s1),
		.data_byte    (byte_s1),
		.target_type  (target_s1),
		.start_offset (start_s1),
		.end_offset   (end_s1),
		.res_valid    (res_valid),
		.found        (found),
		.tlv_offset   (tlv_offset),
		.value_offset (value_offset),
		.value_length (value_length)
	);

	tss_out_reg #(.OFFSET_BITS(OFFSET_BITS)) u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.found        (found),
		.tlv_offset   (tlv_offset),
		.value_offset (value_offset),
		.value_length (value_length),
		.free         (out_free),
		.res          (result_ch)
	);

	// a result is only produced when the result register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result produced into a full result register");

	// back-pressure only comes from a last request blocked behind a result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ch.ready |-> valid_s1 && ctl_s1.last && result_ch.valid)
		else $error("input stalled without a pending result");
endmodule

// File: verif/tss_result_checker.sv
// scoreboard for the tlv type search unit: predicts each region outcome and checks the results
module tss_result_checker (
	input  logic clk,
	input  logic arst_n,
	tss_in_if    byte_ch,
	tss_out_if   result_ch,
	output int   fails,
	output int   pending,
	output int   n_results,
	output int   n_found
);
	typedef struct packed {
		logic        found;
		logic [15:0] tlv_offset;
		logic [15:0] value_offset;
		logic [15:0] value_length;
	} outcome_t;

	outcome_t outcome_q[$];

	// walker state
	tss_pkg::phase_t ph;
	logic [15:0] pos;
	logic [15:0] reg_end;
	logic [7:0]  want_type;
	logic [15:0] skip_left;
	logic [7:0]  ext_hi;
	logic        type_eq;
	logic [15:0] hdr_start;
	logic        hit_f;
	logic [15:0] hit_tlv;
	logic [15:0] hit_val;
	logic [15:0] hit_len;

	task automatic clear_walker(input logic [15:0] so, input logic [15:0] eo,
			input logic [7:0] tgt);
		ph        = tss_pkg::PH_TYPE;
		pos       = so;
		reg_end   = eo;
		want_type = tgt;
		skip_left = '0;
		ext_hi    = '0;
		type_eq   = 1'b0;
		hdr_start = '0;
		hit_f     = 1'b0;
		hit_tlv   = '0;
		hit_val   = '0;
		hit_len   = '0;
	endtask

	// header parsed: decide between hit, skip, next tlv or a failed walk
	task automatic header_complete(input int unsigned len, input int unsigned voff);
		if (voff <= reg_end && len <= reg_end - voff) begin
			if (type_eq) begin
				hit_f   = 1'b1;
				hit_tlv = hdr_start;
				hit_val = 16'(voff);
				hit_len = 16'(len);
				ph      = tss_pkg::PH_DONE;
			end else if (len == 0) begin
				ph = tss_pkg::PH_TYPE;
			end else begin
				skip_left = 16'(len);
				ph        = tss_pkg::PH_SKIP;
			end
		end else begin
			ph = tss_pkg::PH_DONE;
		end
	endtask

	task automatic walk_byte(input logic [7:0] b);
		case (ph)
			tss_pkg::PH_TYPE: begin
				hdr_start = pos;
				type_eq   = (b == want_type);
				ph        = tss_pkg::PH_LEN;
			end
			tss_pkg::PH_LEN: begin
				if (b == tss_pkg::EXT_MARK) ph = tss_pkg::PH_EXT_HI;
				else header_complete(32'(b), 32'(pos) + 1);
			end
			tss_pkg::PH_EXT_HI: begin
				ext_hi = b;
				ph     = tss_pkg::PH_EXT_LO;
			end
			tss_pkg::PH_EXT_LO: begin
				header_complete(32'({ext_hi, b}), 32'(pos) + 1);
			end
			tss_pkg::PH_SKIP: begin
				skip_left = skip_left - 1;
				if (skip_left == 0) ph = tss_pkg::PH_TYPE;
			end
			default: ;
		endcase
	endtask

	task automatic predict_request(input logic [7:0] b, input logic f, input logic l,
			input logic [7:0] tgt, input logic [15:0] so, input logic [15:0] eo);
		outcome_t res;
		if (f) clear_walker(so, eo, tgt);
		// bytes at or past the end are dropped, so pos never wraps
		if (pos < reg_end) begin
			walk_byte(b);
			pos = pos + 1;
		end
		if (l) begin
			ph                 = tss_pkg::PH_DONE;
			res.found          = hit_f;
			res.tlv_offset     = hit_f ? hit_tlv : '0;
			res.value_offset   = hit_f ? hit_val : '0;
			res.value_length   = hit_f ? hit_len : '0;
			outcome_q.push_back(res);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got 0x%0h, predicted 0x%0h",
				n_results, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want_res;
		if (!arst_n) begin
			clear_walker('0, '0, '0);
			outcome_q.delete();
			fails     = 0;
			pending   = 0;
			n_results = 0;
			n_found   = 0;
		end else begin
			// results first: a request taken at this edge cannot be answered yet
			if (result_ch.valid && result_ch.ready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending (found=%0b)",
						result_ch.found));
				end else begin
					want_res = outcome_q.pop_front();
					check_field("found", 16'(result_ch.found), 16'(want_res.found));
					check_field("tlv_offset", result_ch.tlv_offset, want_res.tlv_offset);
					check_field("value_offset", result_ch.value_offset,
						want_res.value_offset);
					check_field("value_length", result_ch.value_length,
						want_res.value_length);
					n_results++;
					if (want_res.found) n_found++;
				end
			end
			if (byte_ch.valid && byte_ch.ready)
				predict_request(byte_ch.data_byte, byte_ch.first, byte_ch.last,
					byte_ch.target_type, byte_ch.start_offset, byte_ch.end_offset);
			pending = outcome_q.size();
		end
	end

endmodule

// File: verif/tlv_type_search_unit_tb.sv
// testbench top for the tlv type search unit: stimulus, flow control and verdict
module tlv_type_search_unit_tb;
	localparam int TOTAL_REQUESTS = 1850;
	// no handshake on either channel for this long means the block is stuck;
	// well above the long result hold-off plus the longest request gap
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 250;

	logic clk;
	logic arst_n;

	tss_in_if  byte_if ();
	tss_out_if res_if ();

	int fails;
	int pending;
	int n_results;
	int n_found;

	logic in_acc = 1'b0;
	int   quiet_cycles = 0;
	int   requests_sent = 0;
	int   regions_sent = 0;

	// flow control knobs for the request and result processes
	bit no_idle     = 1'b0;
	bit burst       = 1'b0;
	bit hold_req    = 1'b0;
	bit hold_active = 1'b0;

	// bytes of the region currently being sent
	logic [7:0] msg_q[$];

	tlv_type_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_if),
		.result_ch (res_if)
	);

	tss_result_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_if),
		.result_ch (res_if),
		.fails     (fails),
		.pending   (pending),
		.n_results (n_results),
		.n_found   (n_found)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request acceptance as seen at the rising edge, read by the driver at the falling edge
	always @(posedge clk) begin
		in_acc <= byte_if.valid && byte_if.ready;
	end

	// watchdog: count cycles without any handshake
	always @(posedge clk) begin
		if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results pending",
				quiet_cycles, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one request: drive at the falling edge, hold until taken, then maybe idle a while
	task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
			input logic [7:0] tgt, input logic [15:0] so, input logic [15:0] eo);
		int r;
		int gap;
		byte_if.valid        = 1'b1;
		byte_if.data_byte    = b;
		byte_if.first        = f;
		byte_if.last         = l;
		byte_if.target_type  = tgt;
		byte_if.start_offset = so;
		byte_if.end_offset   = eo;
		do @(negedge clk); while (!in_acc);
		requests_sent++;
		gap = 0;
		if (!burst && !no_idle) begin
			r = $urandom_range(0, 99);
			// mostly back to back, some short gaps, a few long ones
			if (r < 70) gap = 0;
			else if (r < 97) gap = $urandom_range(1, 3);
			else gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			byte_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// send the first n bytes of msg_q as one region; only the first request
	// carries the real target and offsets, the others get random junk there
	task automatic send_region(input logic [7:0] tgt, input logic [15:0] so,
			input logic [15:0] eo, input int n, input bit with_last);
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				send_byte(msg_q[0], 1'b1, with_last && n == 1, tgt, so, eo);
			else
				send_byte(msg_q[i], 1'b0, with_last && i == n - 1, 8'($urandom),
					16'($urandom), 16'($urandom));
		end
		regions_sent++;
	endtask

	// stop offering requests until every predicted result has come back
	task automatic drain_results();
		byte_if.valid = 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// one random region: mostly well formed tlv chains with random content,
	// the rest truncated or abandoned chains and plain noise
	task automatic random_region();
		int   r;
		int   r2;
		int   n_tlv;
		int   len;
		int   sz;
		int   n_send;
		int   e;
		bit   ext;
		bit   with_last;
		logic [7:0]  tgt;
		logic [15:0] so;
		logic [15:0] eo;
		msg_q.delete();
		r         = $urandom_range(0, 99);
		tgt       = 8'($urandom);
		with_last = 1'b1;
		if (r < 85) begin
			n_tlv = $urandom_range(1, 5);
			for (int k = 0; k < n_tlv; k++) begin
				// the target shows up often, so first-match ordering gets exercised
				msg_q.push_back(($urandom_range(0, 99) < 30) ? tgt : 8'($urandom));
				r2 = $urandom_range(0, 99);
				ext = 1'b0;
				if (r2 < 60) begin
					len = $urandom_range(0, 6);
				end else if (r2 < 75) begin
					len = $urandom_range(0, 8);
					ext = 1'b1;
				end else if (r2 < 85) begin
					// short length that usually overruns the region
					len = $urandom_range(7, 254);
				end else if (r2 < 93) begin
					// extended length with random high and low bytes
					len = $urandom_range(0, 65535);
					ext = 1'b1;
				end else begin
					len = $urandom_range(0, 6);
				end
				if (ext) begin
					msg_q.push_back(tss_pkg::EXT_MARK);
					msg_q.push_back(8'(len >> 8));
				end
				msg_q.push_back(8'(len));
				// value bytes are capped; a longer value runs on into the bytes that follow
				repeat ((len < 12) ? len : 12) msg_q.push_back(8'($urandom));
			end
			sz = msg_q.size();
			r2 = $urandom_range(0, 99);
			if (r2 < 20) begin
				// region right up against the top of the offset range
				e  = 65535 - sz - $urandom_range(0, 3);
				so = 16'((e < 0) ? 0 : e);
			end else if (r2 < 40) begin
				so = 16'($urandom_range(0, 20));
			end else begin
				so = 16'($urandom);
			end
			e  = int'(so) + sz;
			r2 = $urandom_range(0, 99);
			if (r2 < 15) e = e - int'($urandom_range(1, 3));
			else if (r2 < 30) e = e + int'($urandom_range(1, 5));
			if (e > 65535) e = 65535;
			if (e < 0) e = 0;
			eo = 16'(e);
			// extra trailing bytes; those at or past the end are ignored by the block
			if ($urandom_range(0, 99) < 20)
				repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
			n_send = msg_q.size();
			if (r >= 70) begin
				// broken: cut short, and sometimes abandoned without a last
				n_send    = $urandom_range(1, sz);
				with_last = ($urandom_range(0, 3) != 0);
			end
		end else begin
			n_send = $urandom_range(1, 12);
			repeat (n_send) msg_q.push_back(8'($urandom));
			so = 16'($urandom);
			if ($urandom_range(0, 1) == 0) begin
				e  = int'(so) + int'($urandom_range(0, 16));
				eo = 16'((e > 65535) ? 65535 : e);
			end else begin
				eo = 16'($urandom);
			end
		end
		send_region(tgt, so, eo, n_send, with_last);
		// stray requests after a last: ignored, a further last repeats the result
		if (with_last && $urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 8'($urandom),
					16'($urandom), 16'($urandom));
	endtask

	// result side: random ready with short and long drops, a no-idle mode,
	// and a one-off long hold-off requested by the stimulus
	initial begin
		int lo;
		int r;
		res_if.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				res_if.ready = 1'b0;
				hold_active  = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req    = 1'b0;
				hold_active = 1'b0;
			end else if (no_idle) begin
				res_if.ready = 1'b1;
				@(negedge clk);
			end else begin
				res_if.ready = 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				r = $urandom_range(0, 99);
				if (r < 40) lo = 0;
				else if (r < 96) lo = $urandom_range(1, 3);
				else lo = $urandom_range(20, 60);
				if (lo > 0) begin
					res_if.ready = 1'b0;
					repeat (lo) @(negedge clk);
				end
			end
		end
	end

	// request side: reset, directed corners, then the random walk
	initial begin
		bit pressure_done;
		bit paused;
		pressure_done = 1'b0;
		paused        = 1'b0;

		arst_n               = 1'b0;
		byte_if.valid        = 1'b0;
		byte_if.data_byte    = '0;
		byte_if.first        = 1'b0;
		byte_if.last         = 1'b0;
		byte_if.target_type  = '0;
		byte_if.start_offset = '0;
		byte_if.end_offset   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// last with no first since reset: empty region, not found
		send_byte(8'h00, 1'b0, 1'b1, 8'h00, 16'h0000, 16'h0000);

		// first and last on one request: header truncated, not found
		send_byte(8'h3C, 1'b1, 1'b1, 8'h3C, 16'h0000, 16'h0001);

		// plain match behind one skipped tlv
		msg_q = '{8'h05, 8'h02, 8'hAA, 8'h55, 8'h07, 8'h01, 8'hC3};
		send_region(8'h07, 16'd100, 16'd107, 7, 1'b1);

		// extended length match whose value ends exactly at the top offset
		msg_q = '{8'hFF, 8'hFF, 8'h00, 8'h02, 8'h12, 8'h34};
		send_region(8'hFF, 16'd65529, 16'd65535, 6, 1'b1);

		// end equal to start: every byte ignored
		msg_q = '{8'h00, 8'h00};
		send_region(8'h00, 16'd10, 16'd10, 2, 1'b1);

		// value overruns the end, then a repeated last without first
		msg_q = '{8'h03, 8'h05, 8'h99};
		send_region(8'h03, 16'd0, 16'd4, 3, 1'b1);
		send_byte(8'h77, 1'b0, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);

		// region ends inside the extended length
		msg_q = '{8'h09, 8'hFF, 8'h01};
		send_region(8'h09, 16'd200, 16'd203, 3, 1'b1);

		drain_results();

		while (requests_sent < TOTAL_REQUESTS) begin
			no_idle = (requests_sent >= 1000 && requests_sent < 1150);
			if (!pressure_done && requests_sent >= 600) begin
				// hold results off for a long stretch while requests keep coming,
				// so the result register fills and byte_ch backs up
				byte_if.valid = 1'b0;
				hold_req      = 1'b1;
				while (!hold_active) @(negedge clk);
				burst = 1'b1;
				repeat (10) random_region();
				burst         = 1'b0;
				pressure_done = 1'b1;
			end
			if (!paused && requests_sent >= 1400) begin
				drain_results();
				paused = 1'b1;
			end
			random_region();
		end
		no_idle = 1'b0;

		drain_results();
		// a few more cycles to catch any stray result
		repeat (8) @(negedge clk);

		$display("%0d requests in %0d regions, %0d results compared, %0d of them matches",
			requests_sent, regions_sent, n_results, n_found);
		$display("walks with short and extended lengths, truncation, noise, long stall");
		if (fails == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
src/tss_pkg.sv
src/tss_in_if.sv
src/tss_out_if.sv
src/tss_in_reg.sv
src/tss_walker.sv
src/tss_out_reg.sv
src/tlv_type_search_unit.sv
verif/tss_result_checker.sv
verif/tlv_type_search_unit_tb.sv
